[sv/gpacn_pkg.sv]
// Shared types and constants for the gameport axis capture and normalize block.
// No dependencies; imported by every module of the block.
package gpacn_pkg;

    localparam int NUM_AXES  = 4;
    localparam int AX_IDX_W  = 2;
    localparam int TIME_W    = 32;
    localparam int AXIS_W    = 16;
    localparam int NUM_W     = 31;
    localparam int CNT_W     = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam logic CMD_TRIGGER = 1'b0;
    localparam logic CMD_POLL    = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_JOY_SEL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_X    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_Y    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_Y    = 3'd6;

    localparam logic [AXIS_W-1:0] RST_CENTER = 16'd2500;
    localparam logic [AXIS_W-1:0] RST_MIN    = 16'd0;
    localparam logic [AXIS_W-1:0] RST_MAX    = 16'd5000;

    localparam logic [NUM_W-1:0]  NEG_LIMIT  = 31'd32768;
    localparam logic [NUM_W-1:0]  POS_LIMIT  = 31'd32767;

    typedef struct packed {
        logic setup_en;
        logic div_start;
        logic load_out;
        logic axis_idx;
    } ctrl_cmd_t;

    typedef struct packed {
        logic finish;
        logic div_done;
        logic div_busy;
        logic out_free;
    } ctrl_stat_t;

endpackage

[sv/gpacn_div.sv]
// Restoring serial divider, one quotient bit per cycle.
// Depends on gpacn_pkg for operand widths.
module gpacn_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [gpacn_pkg::NUM_W-1:0] num,
    input  logic [gpacn_pkg::AXIS_W-1:0] den,
    output logic [gpacn_pkg::NUM_W-1:0] quo,
    output logic                        busy,
    output logic                        done
);
    import gpacn_pkg::*;

    logic [AXIS_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [AXIS_W:0]   trial;
    logic [AXIS_W:0]   diff;
    logic              ge;

    always_comb begin
        trial     = {rem_reg, quo_reg[NUM_W-1]};
        diff      = trial - {1'b0, den};
        ge        = trial >= {1'b0, den};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = num;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? diff[AXIS_W-1:0] : trial[AXIS_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign quo  = quo_reg;
    assign busy = busy_reg;
    assign done = done_reg;

endmodule

[sv/gpacn_dp.sv]
// Datapath: configuration registers, pulse capture state, scaling setup,
// divider and result register. Depends on gpacn_pkg and gpacn_div.
module gpacn_dp #(
    parameter int TIMEOUT_US = 5000
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [gpacn_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gpacn_pkg::CFG_DAT_W-1:0] cfg_data,
    input  logic                            in_accept,
    input  logic                            s_command,
    input  logic [gpacn_pkg::TIME_W-1:0]    s_time_us,
    input  logic [7:0]                      s_port_bits,
    input  gpacn_pkg::ctrl_cmd_t            cmd,
    output gpacn_pkg::ctrl_stat_t           stat,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_axis_index,
    output logic signed [gpacn_pkg::AXIS_W-1:0] m_axis_value,
    output logic                            m_unresolved,
    output logic [1:0]                      m_buttons,
    output logic                            m_last
);
    import gpacn_pkg::*;

    localparam logic [AXIS_W-1:0] TIMEOUT_T = AXIS_W'(TIMEOUT_US);
    localparam logic [TIME_W-1:0] TIMEOUT_E = TIME_W'(TIMEOUT_US);

    logic              joy_sel_reg;
    logic [AXIS_W-1:0] center_x_reg, min_x_reg, max_x_reg;
    logic [AXIS_W-1:0] center_y_reg, min_y_reg, max_y_reg;

    logic                measuring_reg, measuring_next;
    logic [NUM_AXES-1:0] pending_reg, pending_next;
    logic [TIME_W-1:0]   start_reg, start_next;
    logic [AXIS_W-1:0]   axis_time_reg [NUM_AXES];
    logic [AXIS_W-1:0]   axis_time_next [NUM_AXES];
    logic [1:0]          btn_reg, btn_next;

    logic [TIME_W-1:0] elapsed;
    logic [AXIS_W-1:0] stored;
    logic              finish;

    logic [AX_IDX_W-1:0] ax;
    logic [AXIS_W-1:0]   raw, center, lo, hi, mag, den;
    logic [NUM_W-1:0]    shifted;
    logic                neg;
    logic                neg_reg, degen_reg, unres_reg;
    logic [NUM_W-1:0]    num_reg;
    logic [AXIS_W-1:0]   den_reg;

    logic [NUM_W-1:0]    quo;
    logic                div_busy, div_done;

    logic [AXIS_W:0]     neg_mag;
    logic [AXIS_W-1:0]   value;

    logic                m_valid_reg;
    logic                m_index_reg, m_unres_reg;
    logic [AXIS_W-1:0]   m_value_reg;
    logic [1:0]          m_btn_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            joy_sel_reg  <= 1'b0;
            center_x_reg <= RST_CENTER;
            min_x_reg    <= RST_MIN;
            max_x_reg    <= RST_MAX;
            center_y_reg <= RST_CENTER;
            min_y_reg    <= RST_MIN;
            max_y_reg    <= RST_MAX;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_JOY_SEL:  joy_sel_reg  <= cfg_data[0];
                REG_CENTER_X: center_x_reg <= cfg_data;
                REG_MIN_X:    min_x_reg    <= cfg_data;
                REG_MAX_X:    max_x_reg    <= cfg_data;
                REG_CENTER_Y: center_y_reg <= cfg_data;
                REG_MIN_Y:    min_y_reg    <= cfg_data;
                REG_MAX_Y:    max_y_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        elapsed        = s_time_us - start_reg;
        stored         = (|elapsed[TIME_W-1:AXIS_W]) ? '1 : elapsed[AXIS_W-1:0];
        measuring_next = measuring_reg;
        pending_next   = pending_reg;
        start_next     = start_reg;
        btn_next       = btn_reg;
        for (int i = 0; i < NUM_AXES; i++) begin
            axis_time_next[i] = axis_time_reg[i];
        end
        finish = 1'b0;
        if (in_accept) begin
            if (s_command == CMD_TRIGGER) begin
                measuring_next = 1'b1;
                pending_next   = '1;
                start_next     = s_time_us;
                for (int i = 0; i < NUM_AXES; i++) begin
                    axis_time_next[i] = TIMEOUT_T;
                end
            end else if (measuring_reg) begin
                for (int i = 0; i < NUM_AXES; i++) begin
                    if (pending_reg[i] && !s_port_bits[i]) begin
                        axis_time_next[i] = stored;
                        pending_next[i]   = 1'b0;
                    end
                end
                if (pending_next == '0 || elapsed >= TIMEOUT_E) begin
                    finish         = 1'b1;
                    measuring_next = 1'b0;
                    btn_next       = joy_sel_reg ? ~s_port_bits[7:6] : ~s_port_bits[5:4];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        start_reg <= start_next;
        btn_reg   <= btn_next;
        if (!aresetn) begin
            measuring_reg <= 1'b0;
            pending_reg   <= '0;
            for (int i = 0; i < NUM_AXES; i++) begin
                axis_time_reg[i] <= TIMEOUT_T;
            end
        end else begin
            measuring_reg <= measuring_next;
            pending_reg   <= pending_next;
            for (int i = 0; i < NUM_AXES; i++) begin
                axis_time_reg[i] <= axis_time_next[i];
            end
        end
    end

    always_comb begin
        ax      = {joy_sel_reg, cmd.axis_idx};
        raw     = axis_time_reg[ax];
        center  = cmd.axis_idx ? center_y_reg : center_x_reg;
        lo      = cmd.axis_idx ? min_y_reg : min_x_reg;
        hi      = cmd.axis_idx ? max_y_reg : max_x_reg;
        neg     = raw < center;
        mag     = neg ? (center - raw) : (raw - center);
        den     = neg ? (center - lo) : (hi - center);
        shifted = {mag, 15'd0};
    end

    always_ff @(posedge aclk) begin
        if (cmd.setup_en) begin
            neg_reg   <= neg;
            degen_reg <= neg ? (center <= lo) : (hi <= center);
            unres_reg <= pending_reg[ax];
            num_reg   <= neg ? shifted : (shifted - NUM_W'(mag));
            den_reg   <= den;
        end
    end

    gpacn_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (num_reg),
        .den     (den_reg),
        .quo     (quo),
        .busy    (div_busy),
        .done    (div_done)
    );

    always_comb begin
        neg_mag = (quo > NEG_LIMIT) ? NEG_LIMIT[AXIS_W:0] : quo[AXIS_W:0];
        if (degen_reg) begin
            value = '0;
        end else if (neg_reg) begin
            value = AXIS_W'(-neg_mag);
        end else begin
            value = (quo > POS_LIMIT) ? POS_LIMIT[AXIS_W-1:0] : quo[AXIS_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_index_reg <= cmd.axis_idx;
            m_value_reg <= value;
            m_unres_reg <= unres_reg;
            m_btn_reg   <= btn_reg;
        end
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign stat.finish   = finish;
    assign stat.div_done = div_done;
    assign stat.div_busy = div_busy;
    assign stat.out_free = !m_valid_reg || m_ready;

    assign m_valid      = m_valid_reg;
    assign m_axis_index = m_index_reg;
    assign m_axis_value = m_value_reg;
    assign m_unresolved = m_unres_reg;
    assign m_buttons    = m_btn_reg;
    assign m_last       = m_index_reg;

endmodule

[sv/gpacn_ctrl.sv]
// Controller: accepts items and sequences setup, division and output of both axes.
// Depends on gpacn_pkg for the command and status structs.
module gpacn_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  gpacn_pkg::ctrl_stat_t stat,
    output gpacn_pkg::ctrl_cmd_t  cmd
);
    import gpacn_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SETUP = 3'd1;
    localparam logic [2:0] ST_START = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       idx_reg, idx_next;

    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        s_ready       = 1'b0;
        cmd.setup_en  = 1'b0;
        cmd.div_start = 1'b0;
        cmd.load_out  = 1'b0;
        cmd.axis_idx  = idx_reg;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && stat.finish) begin
                    idx_next   = 1'b0;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                cmd.setup_en = 1'b1;
                state_next   = ST_START;
            end
            ST_START: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                if (stat.div_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    if (idx_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next   = 1'b1;
                        state_next = ST_SETUP;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

[sv/gameport_axis_capture_normalize_top.sv]
// Gameport axis capture and normalize, top level. Depends on gpacn_pkg, gpacn_ctrl, gpacn_dp.
// Trigger items and polls that do not end a measurement are taken while idle, with s_ready high.
// A poll that ends a measurement occupies the block with a ready receiver: per axis setup,
// divider load, one divider step per quotient bit, done, output load; output stalls add to this.
// The first result is loaded at the output before setup of the second axis begins.
// Reset is synchronous, active low: clears control state and restores register defaults.
module gameport_axis_capture_normalize_top #(
    parameter int TIMEOUT_US = 5000
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [gpacn_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gpacn_pkg::CFG_DAT_W-1:0]     cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_command,
    input  logic [gpacn_pkg::TIME_W-1:0]        s_time_us,
    input  logic [7:0]                          s_port_bits,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_axis_index,
    output logic signed [gpacn_pkg::AXIS_W-1:0] m_axis_value,
    output logic                                m_unresolved,
    output logic [1:0]                          m_buttons,
    output logic                                m_last
);
    import gpacn_pkg::*;

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;
    logic       in_accept;

    assign cfg_ready = 1'b1;
    assign in_accept = s_valid && s_ready;

    gpacn_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    gpacn_dp #(
        .TIMEOUT_US (TIMEOUT_US)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_accept    (in_accept),
        .s_command    (s_command),
        .s_time_us    (s_time_us),
        .s_port_bits  (s_port_bits),
        .cmd          (cmd),
        .stat         (stat),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_axis_index (m_axis_index),
        .m_axis_value (m_axis_value),
        .m_unresolved (m_unresolved),
        .m_buttons    (m_buttons),
        .m_last       (m_last)
    );

`ifndef ASSERT_OFF
    a_no_accept_while_dividing: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |-> !stat.div_busy)
        else $error("item accepted while divider busy");

    a_last_not_repeated: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last |=> !(m_valid && m_last))
        else $error("second result repeated");

    a_load_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> stat.out_free && !s_ready)
        else $error("result loaded over a pending item");
`endif

endmodule

[dv/gpacn_checker.sv]
`timescale 1ns / 100ps
// Result checker for the gameport axis capture and normalize block.
// Watches the config, input and result channels, predicts every result pair
// and compares it field by field. Depends on gpacn_pkg.
module gpacn_checker #(
    parameter int TIMEOUT_US = 5000
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [gpacn_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gpacn_pkg::CFG_DAT_W-1:0]     cfg_data,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic                                s_command,
    input  logic [gpacn_pkg::TIME_W-1:0]        s_time_us,
    input  logic [7:0]                          s_port_bits,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic                                m_axis_index,
    input  logic signed [gpacn_pkg::AXIS_W-1:0] m_axis_value,
    input  logic                                m_unresolved,
    input  logic [1:0]                          m_buttons,
    input  logic                                m_last,
    output int                                  mismatches,
    output int                                  results_due
);
    import gpacn_pkg::*;

    typedef struct {
        logic                     axis_index;
        logic signed [AXIS_W-1:0] axis_value;
        logic                     unresolved;
        logic [1:0]               buttons;
        logic                     last;
    } axis_report_t;

    axis_report_t deflections_due[$];
    int           fail_cnt = 0;

    logic              joy_sel;
    logic [AXIS_W-1:0] cal_center [2];
    logic [AXIS_W-1:0] cal_min    [2];
    logic [AXIS_W-1:0] cal_max    [2];
    logic              measuring;
    logic [3:0]        pending;
    logic [TIME_W-1:0] start_us;
    logic [AXIS_W-1:0] pulse_us   [NUM_AXES];

    function automatic logic signed [AXIS_W-1:0] deflection(
        input logic [AXIS_W-1:0] raw,
        input logic [AXIS_W-1:0] ctr,
        input logic [AXIS_W-1:0] lo,
        input logic [AXIS_W-1:0] hi
    );
        longint q;
        if (raw < ctr) begin
            if (ctr <= lo) return '0;
            q = (longint'(ctr) - longint'(raw)) * longint'(NEG_LIMIT)
                / (longint'(ctr) - longint'(lo));
            if (q > longint'(NEG_LIMIT)) q = longint'(NEG_LIMIT);
            return AXIS_W'(-q);
        end
        if (hi <= ctr) return '0;
        q = (longint'(raw) - longint'(ctr)) * longint'(POS_LIMIT)
            / (longint'(hi) - longint'(ctr));
        if (q > longint'(POS_LIMIT)) q = longint'(POS_LIMIT);
        return AXIS_W'(q);
    endfunction

    task automatic clear_state();
        joy_sel   = 1'b0;
        measuring = 1'b0;
        pending   = '0;
        start_us  = '0;
        for (int i = 0; i < 2; i++) begin
            cal_center[i] = RST_CENTER;
            cal_min[i]    = RST_MIN;
            cal_max[i]    = RST_MAX;
        end
        for (int i = 0; i < NUM_AXES; i++) pulse_us[i] = AXIS_W'(TIMEOUT_US);
        deflections_due.delete();
    endtask

    task automatic capture_and_normalize(
        input logic              cmd,
        input logic [TIME_W-1:0] now,
        input logic [7:0]        port
    );
        logic [TIME_W-1:0] elapsed;
        logic [AXIS_W-1:0] stored;
        logic [1:0]        btn;
        int                ax;
        axis_report_t      r;
        if (cmd == CMD_TRIGGER) begin
            measuring = 1'b1;
            pending   = 4'hF;
            start_us  = now;
            for (int i = 0; i < NUM_AXES; i++) pulse_us[i] = AXIS_W'(TIMEOUT_US);
            return;
        end
        if (!measuring) return;
        elapsed = now - start_us;
        stored  = (elapsed > 32'd65535) ? 16'hFFFF : elapsed[AXIS_W-1:0];
        for (int i = 0; i < NUM_AXES; i++) begin
            if (pending[i] && !port[i]) begin
                pulse_us[i] = stored;
                pending[i]  = 1'b0;
            end
        end
        if (pending != '0 && elapsed < 32'(TIMEOUT_US)) return;
        measuring = 1'b0;
        btn = joy_sel ? ~port[7:6] : ~port[5:4];
        for (int i = 0; i < 2; i++) begin
            ax           = (joy_sel ? 2 : 0) + i;
            r.axis_index = i[0];
            r.axis_value = deflection(pulse_us[ax], cal_center[i], cal_min[i], cal_max[i]);
            r.unresolved = pending[ax];
            r.buttons    = btn;
            r.last       = i[0];
            deflections_due.push_back(r);
        end
    endtask

    function automatic void check_field(
        input string              name,
        input logic signed [31:0] expv,
        input logic signed [31:0] actv
    );
        if (expv !== actv) begin
            $error("%s: expected %0d, actual %0d", name, expv, actv);
            fail_cnt++;
        end
    endfunction

    always @(posedge aclk) begin
        axis_report_t e;
        if (!aresetn) begin
            clear_state();
        end else begin
            if (m_valid && m_ready) begin
                if (deflections_due.size() == 0) begin
                    $error("unexpected result: axis_index %0d axis_value %0d",
                           m_axis_index, m_axis_value);
                    fail_cnt++;
                end else begin
                    e = deflections_due.pop_front();
                    check_field("axis_index", e.axis_index, m_axis_index);
                    check_field("axis_value", e.axis_value, m_axis_value);
                    check_field("unresolved", e.unresolved, m_unresolved);
                    check_field("buttons", e.buttons, m_buttons);
                    check_field("last", e.last, m_last);
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_JOY_SEL:  joy_sel       = cfg_data[0];
                    REG_CENTER_X: cal_center[0] = cfg_data;
                    REG_MIN_X:    cal_min[0]    = cfg_data;
                    REG_MAX_X:    cal_max[0]    = cfg_data;
                    REG_CENTER_Y: cal_center[1] = cfg_data;
                    REG_MIN_Y:    cal_min[1]    = cfg_data;
                    REG_MAX_Y:    cal_max[1]    = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) capture_and_normalize(s_command, s_time_us, s_port_bits);
        end
        results_due <= deflections_due.size();
        mismatches  <= fail_cnt;
    end

endmodule

[dv/tb_gameport_axis_capture_normalize_top.sv]
`timescale 1ns / 100ps
// Testbench top for gameport_axis_capture_normalize_top: clock, reset, stimulus and verdict.
// Depends on gpacn_pkg, the block's RTL and gpacn_checker.
module tb_gameport_axis_capture_normalize_top;
    import gpacn_pkg::*;

    localparam int                   ITEM_TARGET  = 1800;
    localparam int                   PHASE_ITEMS  = 260;
    localparam int                   DRAIN_CYCLES = 150;
    localparam int                   STALL_LIMIT  = 20000;
    localparam int                   LONG_HOLD    = 3000;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = 3'd7;

    logic                      aclk = 1'b0;
    logic                      aresetn;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_DAT_W-1:0]      cfg_data;
    logic                      s_valid;
    logic                      s_ready;
    logic                      s_command;
    logic [TIME_W-1:0]         s_time_us;
    logic [7:0]                s_port_bits;
    logic                      m_valid;
    logic                      m_ready;
    logic                      m_axis_index;
    logic signed [AXIS_W-1:0]  m_axis_value;
    logic                      m_unresolved;
    logic [1:0]                m_buttons;
    logic                      m_last;

    int   mismatches;
    int   results_due;
    int   items_sent  = 0;
    int   idle_cycles = 0;
    logic send_burst  = 1'b0;
    logic recv_burst  = 1'b0;

    always #5 aclk = ~aclk;

    gameport_axis_capture_normalize_top u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_time_us    (s_time_us),
        .s_port_bits  (s_port_bits),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_axis_index (m_axis_index),
        .m_axis_value (m_axis_value),
        .m_unresolved (m_unresolved),
        .m_buttons    (m_buttons),
        .m_last       (m_last)
    );

    gpacn_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_time_us    (s_time_us),
        .s_port_bits  (s_port_bits),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_axis_index (m_axis_index),
        .m_axis_value (m_axis_value),
        .m_unresolved (m_unresolved),
        .m_buttons    (m_buttons),
        .m_last       (m_last),
        .mismatches   (mismatches),
        .results_due  (results_due)
    );

    task automatic send_item(
        input logic              cmd,
        input logic [TIME_W-1:0] stamp,
        input logic [7:0]        port
    );
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_command   <= cmd;
        s_time_us   <= stamp;
        s_port_bits <= port;
        do @(posedge aclk); while (!s_ready);
        if ($urandom_range(0, 59) == 0) send_burst = ~send_burst;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (results_due != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic program_calibration(input int mode);
        logic [CFG_IDX_W-1:0] idx [8];
        logic [CFG_DAT_W-1:0] dat [8];
        logic [AXIS_W-1:0]    c;
        int                   n;
        n = 7;
        idx[0] = REG_JOY_SEL;
        dat[0] = {15'($urandom), mode[0]};
        for (int i = 0; i < 2; i++) begin
            idx[1 + 3*i] = i ? REG_CENTER_Y : REG_CENTER_X;
            idx[2 + 3*i] = i ? REG_MIN_Y : REG_MIN_X;
            idx[3 + 3*i] = i ? REG_MAX_Y : REG_MAX_X;
            c = AXIS_W'($urandom_range(1000, 3000));
            case (mode % 7)
                1: begin
                    dat[1 + 3*i] = 16'd0;
                    dat[2 + 3*i] = 16'hFFFF;
                    dat[3 + 3*i] = 16'hFFFF;
                end
                2: begin
                    dat[1 + 3*i] = 16'hFFFF;
                    dat[2 + 3*i] = i ? 16'hFFFF : 16'd0;
                    dat[3 + 3*i] = i ? 16'hFFFF : 16'd0;
                end
                3: begin
                    dat[1 + 3*i] = c;
                    dat[2 + 3*i] = c;
                    dat[3 + 3*i] = c;
                end
                4: begin
                    dat[1 + 3*i] = c;
                    dat[2 + 3*i] = CFG_DAT_W'($urandom_range(c, 65535));
                    dat[3 + 3*i] = CFG_DAT_W'($urandom_range(0, c));
                end
                5: begin
                    dat[1 + 3*i] = c;
                    dat[2 + 3*i] = c - 16'd1;
                    dat[3 + 3*i] = c + 16'd1;
                end
                default: begin
                    dat[1 + 3*i] = c;
                    dat[2 + 3*i] = CFG_DAT_W'($urandom_range(0, c - 1));
                    dat[3 + 3*i] = CFG_DAT_W'($urandom_range(c + 1, 6000));
                end
            endcase
        end
        if (mode % 7 == 3) begin
            idx[7] = REG_UNUSED;
            dat[7] = CFG_DAT_W'($urandom);
            n = 8;
        end
        for (int k = 0; k < n; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= dat[k];
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic run_directed();
        send_item(CMD_POLL, 32'h1234_5678, 8'h00);
        send_item(CMD_TRIGGER, 32'd100, 8'hFF);
        send_item(CMD_POLL, 32'd150, 8'hF0);
        send_item(CMD_TRIGGER, 32'hFFFF_FF00, 8'h00);
        send_item(CMD_POLL, 32'h0000_0100, 8'h0A);
        send_item(CMD_POLL, 32'h0000_1288, 8'h0F);
        send_item(CMD_TRIGGER, 32'd0, 8'h55);
        send_item(CMD_TRIGGER, 32'd10, 8'hAA);
        send_item(CMD_POLL, 32'd9, 8'hA0);
        send_item(CMD_TRIGGER, 32'd0, 8'hFF);
        send_item(CMD_POLL, 32'd70000, 8'hF5);
        send_item(CMD_TRIGGER, 32'd200, 8'h3C);
        send_item(CMD_POLL, 32'd200, 8'h00);
        send_item(CMD_TRIGGER, 32'd1000, 8'hFF);
        send_item(CMD_POLL, 32'd5999, 8'hFF);
        send_item(CMD_POLL, 32'd5999, 8'hF7);
        send_item(CMD_POLL, 32'd5999, 8'h70);
        send_item(CMD_TRIGGER, 32'd7000, 8'hFF);
        send_item(CMD_POLL, 32'd9500, 8'hDC);
        send_item(CMD_POLL, 32'd12000, 8'hE0);
        send_item(CMD_TRIGGER, 32'h8000_0000, 8'hFF);
        send_item(CMD_POLL, 32'h8000_1388, 8'hFF);
        send_item(CMD_POLL, 32'h8000_2000, 8'h00);
        items_sent += 23;
    endtask

    task automatic run_measurement();
        logic [TIME_W-1:0] base;
        logic [7:0]        port;
        logic [3:0]        seen;
        longint            fall [NUM_AXES];
        longint            e;
        base = $urandom;
        if ($urandom_range(0, 9) == 0) base = 32'hFFFF_FFFF - $urandom_range(0, 6000);
        for (int i = 0; i < NUM_AXES; i++) begin
            case ($urandom_range(0, 9))
                0:       fall[i] = 64'h7FFF_FFFF_FFFF;
                1:       fall[i] = longint'($urandom_range(0, 50));
                default: fall[i] = longint'($urandom_range(0, 5100));
            endcase
        end
        send_item(CMD_TRIGGER, base, 8'($urandom));
        items_sent++;
        if ($urandom_range(0, 19) == 0) begin
            base = base + $urandom_range(0, 300);
            send_item(CMD_TRIGGER, base, 8'($urandom));
            items_sent++;
        end
        seen = '0;
        e    = 0;
        while (seen != 4'hF && e < 5000) begin
            case ($urandom_range(0, 29))
                0:       e += longint'($urandom_range(5000, 200000));
                1:       e += longint'($urandom);
                2:       e += 0;
                default: e += longint'($urandom_range(1, 600));
            endcase
            port[7:4] = 4'($urandom);
            for (int i = 0; i < NUM_AXES; i++) port[i] = (e < fall[i]);
            if ($urandom_range(0, 14) == 0) port[3:0] = 4'($urandom);
            send_item(CMD_POLL, base + TIME_W'(e), port);
            items_sent++;
            seen |= ~port[3:0];
            if ($urandom_range(0, 39) == 0) break;
        end
    endtask

    initial begin
        aresetn     <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        s_valid     <= 1'b0;
        s_command   <= CMD_POLL;
        s_time_us   <= '0;
        s_port_bits <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        for (int phase = 1; items_sent < ITEM_TARGET; phase++) begin
            settle();
            program_calibration(phase);
            for (int start = items_sent; items_sent - start < PHASE_ITEMS; ) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_item(1'($urandom_range(0, 1)), $urandom, 8'($urandom));
                    items_sent++;
                end else begin
                    run_measurement();
                end
            end
        end
        settle();
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        int stall;
        int taken;
        taken = 0;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            stall = recv_burst ? 0 : $urandom_range(0, 11);
            if (taken == 40) stall = LONG_HOLD;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            taken++;
            if ($urandom_range(0, 49) == 0) recv_burst = ~recv_burst;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

endmodule
